// ----- rtl/apvfd_pkg.sv -----
package apvfd_pkg;

	localparam logic [31:0] END_MARKER   = 32'hfafa_fafa;
	localparam logic [23:0] FRAME_TAG    = 24'h41_4443;
	localparam logic [15:0] DEFAULT_SIZE = 16'd4000;
	localparam logic [2:0]  BODY_POS     = 3'd7;
	localparam logic [2:0]  FEC_WORD_POS = 3'd2;
	localparam logic [7:0]  MAX_CHANNEL  = 8'd15;
	localparam logic [7:0]  MAX_FEC      = 8'd15;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam int NUM_REGS = 4;

	typedef struct packed {
		logic [31:0] word;
		logic        start_of_buffer;
	} apvfd_in_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [7:0]  fec_number;
		logic [3:0]  channel;
		logic [15:0] frame_size;
		logic        last_of_frame;
		logic        kind;
	} apvfd_out_t;

	typedef logic [NUM_REGS-1:0][63:0] apvfd_mask_t;

	// results produced by one word, packed to the front
	typedef struct packed {
		logic [1:0] cnt;
		apvfd_out_t r0;
		apvfd_out_t r1;
	} apvfd_push_t;

endpackage

// ----- rtl/apvfd_regs.sv -----
module apvfd_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready,
	output apvfd_pkg::apvfd_mask_t masks
);
	import apvfd_pkg::*;

	apvfd_mask_t mask_q;
	logic [1:0]  idx;
	logic        wr_en;

	assign idx    = paddr[4:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = mask_q[idx];
	assign masks  = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (wr_en) begin
			mask_q[idx] <= pwdata;
		end
	end

endmodule

// ----- rtl/apvfd_core.sv -----
module apvfd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  apvfd_pkg::apvfd_in_t  in_data,
	output logic                  in_stall,
	input  logic                  room,
	input  apvfd_pkg::apvfd_mask_t masks,
	output apvfd_pkg::apvfd_push_t push
);
	import apvfd_pkg::*;

	// input register
	logic        valid_s1;
	apvfd_in_t   in_s1;
	logic        go;
	logic        load;

	// decode state
	logic [2:0]  hp_q, hp_n;
	logic [7:0]  fec_q, fec_n;
	logic [3:0]  fch_q, fch_n;
	logic        exp_q, exp_n;
	logic [15:0] size_q, size_n;
	logic [1:0]  hc_q, hc_n;
	logic        stop_q, stop_n;
	logic [31:0] hw0_q, hw0_n;
	logic [31:0] hw1_q, hw1_n;

	logic [31:0] w;
	logic        is_end;
	logic        is_tag;
	logic        active;
	logic [5:0]  bit_sel;
	logic        a_v, b_v;
	apvfd_out_t  a, b;

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			in_s1 <= in_data;
		end
	end

	assign w      = in_s1.word;
	assign is_end = (w == END_MARKER);
	assign is_tag = (w[31:8] == FRAME_TAG);

	always_comb begin
		// start of buffer resets the frame state, fec stays
		hp_n   = hp_q;
		fec_n  = fec_q;
		fch_n  = fch_q;
		exp_n  = exp_q;
		size_n = size_q;
		hc_n   = hc_q;
		stop_n = stop_q;
		hw0_n  = hw0_q;
		hw1_n  = hw1_q;
		if (in_s1.start_of_buffer) begin
			hp_n   = '0;
			fch_n  = '0;
			exp_n  = 1'b0;
			size_n = DEFAULT_SIZE;
			hc_n   = '0;
			stop_n = 1'b0;
		end

		bit_sel = {fec_q[1:0], fch_n};
		active  = (fec_q <= MAX_FEC) && masks[fec_q[3:2]][bit_sel];

		a_v = 1'b0;
		b_v = 1'b0;
		a   = '{data_word: hw0_q, fec_number: fec_q, channel: fch_n,
			frame_size: size_n, last_of_frame: 1'b0, kind: KIND_DATA};
		b   = '{data_word: hw1_q, fec_number: fec_q, channel: fch_n,
			frame_size: size_n, last_of_frame: 1'b1, kind: KIND_DATA};

		if (!stop_n) begin
			if (hp_n != BODY_POS) begin
				if (hp_n == FEC_WORD_POS) begin
					fec_n = w[7:0];
				end
				hp_n = hp_n + 3'd1;
			end else if (is_end) begin
				// flush everything held, nothing dropped
				if (hc_n[1]) begin
					a_v = active;
					b_v = active;
				end else if (hc_n == 2'd1) begin
					a_v = active;
					a.last_of_frame = 1'b1;
				end
				hc_n   = '0;
				fch_n  = '0;
				stop_n = 1'b1;
			end else if (exp_n) begin
				size_n = w[15:0];
				hc_n   = '0;
				exp_n  = 1'b0;
			end else if (is_tag) begin
				// close previous frame, newest held word is dropped
				if (hc_n[1]) begin
					a_v = active;
					a.last_of_frame = 1'b1;
				end
				hc_n = '0;
				if (w[7:0] > MAX_CHANNEL) begin
					b_v = 1'b1;
					b   = '{data_word: w, fec_number: fec_q, channel: '0,
						frame_size: '0, last_of_frame: 1'b0, kind: KIND_ERROR};
					stop_n = 1'b1;
				end else begin
					fch_n = w[3:0];
					exp_n = 1'b1;
				end
			end else begin
				if (hc_n[1]) begin
					a_v   = active;
					hw0_n = hw1_q;
					hw1_n = w;
				end else if (hc_n == 2'd0) begin
					hw0_n = w;
					hc_n  = 2'd1;
				end else begin
					hw1_n = w;
					hc_n  = 2'd2;
				end
			end
		end

		push.cnt = {1'b0, a_v} + {1'b0, b_v};
		push.r0  = a_v ? a : b;
		push.r1  = b;
		if (!go) begin
			push.cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q   <= '0;
			fec_q  <= '0;
			fch_q  <= '0;
			exp_q  <= 1'b0;
			size_q <= DEFAULT_SIZE;
			hc_q   <= '0;
			stop_q <= 1'b1;
		end else if (go) begin
			hp_q   <= hp_n;
			fec_q  <= fec_n;
			fch_q  <= fch_n;
			exp_q  <= exp_n;
			size_q <= size_n;
			hc_q   <= hc_n;
			stop_q <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hw0_q <= hw0_n;
			hw1_q <= hw1_n;
		end
	end

	// two results only come from the end marker or a bad frame header
	a_two_src: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (is_end || is_tag))
		else $error("two results from a plain data word");

	a_hold_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != 2'd3)
		else $error("hold count out of range");

endmodule

// ----- rtl/apvfd_outq.sv -----
module apvfd_outq #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  apvfd_pkg::apvfd_push_t push,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_stall,
	output apvfd_pkg::apvfd_out_t  out_data
);
	import apvfd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIM = CW'(DEPTH - 2);

	apvfd_out_t    mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q, wr_p1, wr_p2, rd_p1;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + AW'(1);
	endfunction

	assign wr_p1     = inc(wr_q);
	assign wr_p2     = inc(wr_p1);
	assign rd_p1     = inc(rd_q);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	// space for two results after this cycle's pop
	assign room      = (count_q <= ROOM_LIM) || (pop && (count_q <= ROOM_LIM + CW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_p1;
			end
			case (push.cnt)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("push without room");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(1) && pop && push.cnt == 2'd0) |=> !out_valid)
		else $error("queue did not drain");

endmodule

// ----- rtl/apv_frame_deframer.sv -----
// APV frame deframer. Takes an event buffer one 32-bit word at a time and
// splits it into per-channel frames: equipment header words are skipped
// (the FEC number comes from header word 2), each frame header 0x414443xx
// opens channel xx, the following word sets the frame size, and the last
// data word of a frame is dropped when the next frame header arrives. The
// end marker 0xfafafafa flushes the held words and stops the event until
// the next word flagged start_of_buffer. Only channels enabled in the
// 64-bit active masks (16 bits per FEC, four FECs per register at byte
// address 8*i) are emitted; a channel number above 15 gives one error word
// and stops the event.
// Rate: one input word per cycle while in_stall is low. An accepted word is
// registered, decoded and written into the result queue, whose count drives
// out_valid. A word yields at most two result words; results leave one per
// cycle while out_stall is low through a QUEUE_DEPTH entry result queue, and
// the input stalls only when that queue cannot take two more results, i.e.
// when downstream stalls or an end marker flush or error word backs it up.
module apv_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  apvfd_pkg::apvfd_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output apvfd_pkg::apvfd_out_t out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);
	import apvfd_pkg::*;

	apvfd_mask_t masks;
	apvfd_push_t push;
	logic        room;

	// register file for the active channel masks
	apvfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.masks   (masks)
	);

	// input register plus single-pass decode of one word
	apvfd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_stall (in_stall),
		.room     (room),
		.masks    (masks),
		.push     (push)
	);

	// result registers, drained one word per cycle while out_stall is low
	apvfd_outq #(
		.DEPTH (QUEUE_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
